@@ hw/rtl/tsfq_pkg.sv @@
package tsfq_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned STATUS_W = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic                push_arr;   // write value on arrival stack
        logic                push_dep0;  // write value at departure bottom
        logic                pop_dep;    // drop departure top
        logic                front_dep;  // load front from departure read
        logic                xfer_rd;    // take arrival top (read issued)
        logic                xfer_wr;    // write moved word on departure
        logic                st_we;
        logic [STATUS_W-1:0] st;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic dep_empty;
        logic dep_one;
        logic arr_empty;
        logic q_empty;
        logic full;
    } sts_t;

endpackage

@@ hw/rtl/tsfq_ram.sv @@
module tsfq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tsfq_ctrl.sv @@
module tsfq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           command,
    input  tsfq_pkg::sts_t sts,
    output tsfq_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done
);

    import tsfq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_XRD   = 2'd1;
    localparam logic [1:0] S_XWR   = 2'd2;
    localparam logic [1:0] S_FRONT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_PUSH)
                    begin
                        done_next = 1'b1;
                        cmd.st_we = 1'b1;
                        if (sts.full)
                        begin
                            cmd.st = STATUS_OVERFLOW;
                        end
                        else if (sts.dep_empty)
                        begin
                            cmd.st        = STATUS_OK;
                            cmd.push_dep0 = 1'b1;
                        end
                        else
                        begin
                            cmd.st       = STATUS_OK;
                            cmd.push_arr = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.st_we = 1'b1;
                        if (sts.q_empty)
                        begin
                            cmd.st    = STATUS_UNDERFLOW;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            cmd.st      = STATUS_OK;
                            cmd.pop_dep = 1'b1;
                            if (!sts.dep_one)
                            begin
                                state_next = S_FRONT;   // read new top
                            end
                            else if (!sts.arr_empty)
                            begin
                                state_next = S_XRD;     // refill departure
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                    end
                end
            end
            S_XRD:
            begin
                cmd.xfer_rd = 1'b1;
                state_next  = S_XWR;
            end
            S_XWR:
            begin
                cmd.xfer_wr = 1'b1;
                if (sts.arr_empty)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_XRD;
                end
            end
            S_FRONT:
            begin
                cmd.front_dep = 1'b1;
                state_next    = S_IDLE;
                done_next     = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

@@ hw/rtl/tsfq_dpath.sv @@
module tsfq_dpath #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tsfq_pkg::cmd_t                    cmd,
    input  logic signed [tsfq_pkg::WORD_W-1:0] value,
    output tsfq_pkg::sts_t                    sts,
    output logic signed [tsfq_pkg::WORD_W-1:0] front_word,
    output logic                              not_empty,
    output logic [tsfq_pkg::COUNT_W-1:0]      word_count,
    output logic [tsfq_pkg::STATUS_W-1:0]     status
);

    import tsfq_pkg::*;

    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    arr_top_reg, arr_top_next;
    logic [CNT_W-1:0]    dep_top_reg, dep_top_next;
    logic [CNT_W-1:0]    total;
    logic [WORD_W-1:0]   front_reg, front_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                arr_we;
    logic [ADDR_W-1:0]   arr_waddr, arr_raddr;
    logic [WORD_W-1:0]   arr_rdata;
    logic                dep_we;
    logic [ADDR_W-1:0]   dep_waddr, dep_raddr;
    logic [WORD_W-1:0]   dep_wdata, dep_rdata;

    assign total = arr_top_reg + dep_top_reg;

    assign sts.dep_empty = (dep_top_reg == '0);
    assign sts.dep_one   = (dep_top_reg == CNT_W'(1));
    assign sts.arr_empty = (arr_top_reg == '0);
    assign sts.q_empty   = (total == '0);
    assign sts.full      = (total >= CNT_W'(CAPACITY));

    // arrival: push at top, transfer reads top-1
    assign arr_we    = cmd.push_arr;
    assign arr_waddr = arr_top_reg[ADDR_W-1:0];
    assign arr_raddr = ADDR_W'(arr_top_reg - CNT_W'(1));

    // departure: pop exposes top-2 as the new front
    assign dep_we    = cmd.push_dep0 | cmd.xfer_wr;
    assign dep_waddr = cmd.push_dep0 ? '0 : dep_top_reg[ADDR_W-1:0];
    assign dep_wdata = cmd.push_dep0 ? value : arr_rdata;
    assign dep_raddr = ADDR_W'(dep_top_reg - CNT_W'(2));

    tsfq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_arr_ram (
        .clk   (clk),
        .we    (arr_we),
        .waddr (arr_waddr),
        .wdata (value),
        .raddr (arr_raddr),
        .rdata (arr_rdata)
    );

    tsfq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_dep_ram (
        .clk   (clk),
        .we    (dep_we),
        .waddr (dep_waddr),
        .wdata (dep_wdata),
        .raddr (dep_raddr),
        .rdata (dep_rdata)
    );

    always_comb
    begin
        arr_top_next = arr_top_reg;
        dep_top_next = dep_top_reg;
        front_next   = front_reg;
        status_next  = status_reg;
        if (cmd.st_we)
        begin
            status_next = cmd.st;
        end
        if (cmd.push_arr)
        begin
            arr_top_next = arr_top_reg + CNT_W'(1);
        end
        if (cmd.push_dep0)
        begin
            dep_top_next = CNT_W'(1);
            front_next   = value;
        end
        if (cmd.pop_dep)
        begin
            dep_top_next = dep_top_reg - CNT_W'(1);
        end
        if (cmd.front_dep)
        begin
            front_next = dep_rdata;
        end
        if (cmd.xfer_rd)
        begin
            arr_top_next = arr_top_reg - CNT_W'(1);
        end
        if (cmd.xfer_wr)
        begin
            dep_top_next = dep_top_reg + CNT_W'(1);
            front_next   = arr_rdata;   // last word moved is the oldest
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arr_top_reg <= '0;
            dep_top_reg <= '0;
        end
        else
        begin
            arr_top_reg <= arr_top_next;
            dep_top_reg <= dep_top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg  <= front_next;
        status_reg <= status_next;
    end

    assign front_word = sts.dep_empty ? '0 : signed'(front_reg);
    assign not_empty  = !sts.q_empty;
    assign word_count = COUNT_W'(total);
    assign status     = status_reg;

endmodule

@@ hw/rtl/two_stack_fifo_queue.sv @@
// FIFO queue of 32-bit signed words built from two stacks in RAM.
// Command channel: drive command (0 push value, 1 pop) and value with start
// high; the beat is taken on a rising edge where start is high and busy low.
// Result channel: done pulses for one cycle; front_word, not_empty,
// word_count and status hold the result during that cycle. The receiver
// cannot stall, so the result must be sampled on that edge.
// Path from accept to done:
//   push, overflow, underflow, pop leaving the last word: straight from idle
//   pop with words left on the departure stack: via the front state (RAM
//   read of the new front)
//   pop that empties the departure stack: N words moved from the arrival
//   stack, each by a read state then a write state.
// A new command may be accepted in the cycle done is high. Each word moves
// between the stacks at most once. A push into an empty queue goes straight
// to the departure stack. Reset clears both stack pointers; the RAM contents
// need no clearing, as only entries below a pointer are ever read.
// front_word is zero when empty.
module two_stack_fifo_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic signed [tsfq_pkg::WORD_W-1:0]  value,
    output logic                               done,
    output logic signed [tsfq_pkg::WORD_W-1:0]  front_word,
    output logic                               not_empty,
    output logic [tsfq_pkg::COUNT_W-1:0]       word_count,
    output logic [tsfq_pkg::STATUS_W-1:0]      status
);

    import tsfq_pkg::*;

    cmd_t cmd;   // controller commands to the datapath
    sts_t sts;   // pointer status back to the controller

    tsfq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    // Stack RAMs, pointers, front word and status register.
    tsfq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .sts        (sts),
        .front_word (front_word),
        .not_empty  (not_empty),
        .word_count (word_count),
        .status     (status)
    );

endmodule

@@ test/two_stack_fifo_queue_test.sv @@
`timescale 1ns / 1ps

module two_stack_fifo_queue_test;

    import tsfq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BEATS  = 800;
    // Longest accept-to-done: pop that moves a full arrival stack, plus slack.
    localparam int SETTLE_CYCLES = 1 + 2 * CAPACITY + 8;
    localparam int DRAIN_LIMIT   = 4000;

    // One result beat, as seen on the result ports.
    typedef struct packed {
        logic signed [WORD_W-1:0]   front;
        logic                       filled;
        logic [COUNT_W-1:0]         count;
        logic [STATUS_W-1:0]        stat;
    } queue_report_t;

    // Directed stimulus row. When fixed is set, the typed-in report is the
    // expectation; otherwise the predictor supplies it.
    typedef struct packed {
        logic                       cmd;
        logic signed [WORD_W-1:0]   word;
        logic                       fixed;
        queue_report_t              report;
    } directed_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       command;
    logic signed [WORD_W-1:0]   value;
    logic                       done;
    logic signed [WORD_W-1:0]   front_word;
    logic                       not_empty;
    logic [COUNT_W-1:0]         word_count;
    logic [STATUS_W-1:0]        status;

    two_stack_fifo_queue #(
        .CAPACITY   (CAPACITY)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .value      (value),
        .done       (done),
        .front_word (front_word),
        .not_empty  (not_empty),
        .word_count (word_count),
        .status     (status)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: the two stacks and their fill levels.
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0]   arrival_mem   [CAPACITY];
    logic signed [WORD_W-1:0]   departure_mem [CAPACITY];
    int unsigned                arrival_fill;
    int unsigned                departure_fill;

    // Reports predicted for accepted beats, oldest first.
    queue_report_t              pending_reports [$];

    int                         mismatches;
    int                         reports_checked;
    int                         underflows_seen;
    int                         overflows_seen;
    int                         full_hits;
    int                         peak_count;

    // Sender idle percentage per random phase. The receiver has no stall,
    // so the receiver-only phase collapses into the no-idle one.
    int                         idle_plan [3] = '{0, 68, 30};

    // Directed walk: empty pop, extremes, drain to empty, fill to capacity,
    // push on full, then the long transfer pop and one more push.
    directed_row_t plan [DIRECTED_ROWS] = '{
        // pop on an empty queue after reset
        '{CMD_POP,  32'h00000000, 1'b1, '{32'h00000000, 1'b0, 5'd0, STATUS_UNDERFLOW}},
        // most negative word goes in first and stays at the front
        '{CMD_PUSH, 32'h80000000, 1'b1, '{32'h80000000, 1'b1, 5'd1, STATUS_OK}},
        '{CMD_PUSH, 32'h7FFFFFFF, 1'b1, '{32'h80000000, 1'b1, 5'd2, STATUS_OK}},
        '{CMD_POP,  32'h00000000, 1'b1, '{32'h7FFFFFFF, 1'b1, 5'd1, STATUS_OK}},
        // last word leaves: front reads zero
        '{CMD_POP,  32'hFFFFFFFF, 1'b1, '{32'h00000000, 1'b0, 5'd0, STATUS_OK}},
        '{CMD_POP,  32'h00000000, 1'b1, '{32'h00000000, 1'b0, 5'd0, STATUS_UNDERFLOW}},
        // fill to capacity
        '{CMD_PUSH, 32'h12345678, 1'b0, '0},
        '{CMD_PUSH, 32'h00000000, 1'b0, '0},
        '{CMD_PUSH, 32'hFFFFFFFF, 1'b0, '0},
        '{CMD_PUSH, 32'h00000001, 1'b0, '0},
        '{CMD_PUSH, 32'h55555555, 1'b0, '0},
        '{CMD_PUSH, 32'hAAAAAAAA, 1'b0, '0},
        '{CMD_PUSH, 32'h7FFFFFFE, 1'b0, '0},
        '{CMD_PUSH, 32'h80000001, 1'b0, '0},
        '{CMD_PUSH, 32'h0F0F0F0F, 1'b0, '0},
        '{CMD_PUSH, 32'hF0F0F0F0, 1'b0, '0},
        '{CMD_PUSH, 32'h00010000, 1'b0, '0},
        '{CMD_PUSH, 32'hFFFF0000, 1'b0, '0},
        '{CMD_PUSH, 32'h0000FFFF, 1'b0, '0},
        '{CMD_PUSH, 32'h3C3C3C3C, 1'b0, '0},
        '{CMD_PUSH, 32'hC3C3C3C3, 1'b0, '0},
        '{CMD_PUSH, 32'h00000002, 1'b0, '0},
        // push on a full queue is dropped
        '{CMD_PUSH, 32'h7FFFFFFF, 1'b1, '{32'h12345678, 1'b1, 5'd16, STATUS_OVERFLOW}},
        // pop that forces the full arrival stack across
        '{CMD_POP,  32'h00000000, 1'b0, '0},
        '{CMD_PUSH, 32'h80000000, 1'b0, '0}
    };

    // Move the whole arrival stack onto an empty departure stack.
    function automatic void refill_departure();
        if (departure_fill != 0)
            return;
        while (arrival_fill > 0 && departure_fill < CAPACITY)
        begin
            arrival_fill--;
            departure_mem[departure_fill] = arrival_mem[arrival_fill];
            departure_fill++;
        end
    endfunction

    // Apply one command to the predicted queue and return its report.
    function automatic queue_report_t queue_step(input logic cmd,
                                                 input logic signed [WORD_W-1:0] word);
        queue_report_t rep;
        int unsigned   total;
        rep   = '0;
        total = arrival_fill + departure_fill;
        rep.stat = STATUS_OK;
        if (cmd == CMD_PUSH)
        begin
            if (total >= CAPACITY || arrival_fill >= CAPACITY)
                rep.stat = STATUS_OVERFLOW;
            else
            begin
                arrival_mem[arrival_fill] = word;
                arrival_fill++;
            end
        end
        else
        begin
            if (total == 0)
                rep.stat = STATUS_UNDERFLOW;
            else
            begin
                refill_departure();
                if (departure_fill > 0)
                    departure_fill--;
            end
        end
        // front always comes from the departure top after the step
        refill_departure();
        total      = arrival_fill + departure_fill;
        rep.filled = (total != 0);
        rep.count  = total[COUNT_W-1:0];
        if (departure_fill > 0)
            rep.front = departure_mem[departure_fill - 1];
        return rep;
    endfunction

    // Drive one command beat; returns at the edge that accepts it.
    // Idle cycles are drawn per cycle at idle_pct percent.
    task automatic send_beat(input logic cmd, input logic signed [WORD_W-1:0] word,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        value   <= word;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending and wait until every predicted report has come back.
    task automatic wait_drained();
        int k;
        start <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && pending_reports.size() != 0; k++)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done beat is matched to the oldest prediction.
    // Outputs are sampled on the edge, before the block's own updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        queue_report_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result beat, front %0h count %0d status %0d",
                         $realtime, front_word, word_count, status);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("front_word", want.front, front_word);
                check_field("not_empty", WORD_W'(want.filled), WORD_W'(not_empty));
                check_field("word_count", WORD_W'(want.count), WORD_W'(word_count));
                check_field("status", WORD_W'(want.stat), WORD_W'(status));
                reports_checked++;
                if (want.stat == STATUS_UNDERFLOW)
                    underflows_seen++;
                if (want.stat == STATUS_OVERFLOW)
                    overflows_seen++;
                if (int'(want.count) == CAPACITY)
                    full_hits++;
                if (int'(want.count) > peak_count)
                    peak_count = int'(want.count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        queue_report_t           rep;
        logic                    cmd;
        logic signed [WORD_W-1:0] word;
        int                      burst_left;
        int                      push_pct;
        int                      phase;
        int                      beat;
        int                      pick;

        mismatches      = 0;
        reports_checked = 0;
        underflows_seen = 0;
        overflows_seen  = 0;
        full_hits       = 0;
        peak_count      = 0;
        arrival_fill    = 0;
        departure_fill  = 0;
        burst_left      = 0;
        push_pct        = 50;

        rst_n   = 1'b0;
        start   = 1'b0;
        command = CMD_PUSH;
        value   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_beat(plan[i].cmd, plan[i].word, 0);
            rep = queue_step(plan[i].cmd, plan[i].word);
            if (plan[i].fixed)
                pending_reports.push_back(plan[i].report);
            else
                pending_reports.push_back(rep);
        end
        // Hold off until the table has fully drained.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Random phases: bursts lean toward push or pop so the queue swings
        // between empty and full, with extremes mixed into the data.
        for (phase = 0; phase < 3; phase++)
        begin
            for (beat = 0; beat < RANDOM_BEATS / 3; beat++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(40, 8);
                    pick       = $urandom_range(2);
                    push_pct   = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
                end
                burst_left--;
                cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
                pick = $urandom_range(9);
                case (pick)
                    0: word = 32'h80000000;
                    1: word = 32'h7FFFFFFF;
                    2: word = 32'hFFFFFFFF;
                    3: word = 32'h00000000;
                    default: word = $urandom;
                endcase
                send_beat(cmd, word, idle_plan[phase]);
                pending_reports.push_back(queue_step(cmd, word));
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $realtime,
                     pending_reports.size());
            mismatches++;
        end

        $display("checked %0d result beats: %0d underflow, %0d overflow, %0d at capacity",
                 reports_checked, underflows_seen, overflows_seen, full_hits);
        $display("peak depth %0d; sender idle at 0, 68 and 30 percent; %0d mismatches",
                 peak_count, mismatches);
        if (mismatches == 0)
            $display("two_stack_fifo_queue test passed");
        else
            $display("two_stack_fifo_queue test failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("two_stack_fifo_queue test failed");
        $finish;
    end

endmodule
